FILE: sv/kte_pkg.sv
`timescale 1ns / 1ps
package kte_pkg;
  localparam int MaxKeys = 16;
  localparam int IdxW = $clog2(MaxKeys);
  localparam int CntW = $clog2(MaxKeys + 1);
  localparam int KeyW = 64;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    EASE_LIN   = 2'd0,
    EASE_IN    = 2'd1,
    EASE_OUT   = 2'd2,
    EASE_INOUT = 2'd3
  } ease_t;

  typedef enum logic [1:0] {
    REG_EASE   = 2'd0,
    REG_LOOP   = 2'd1,
    REG_PERIOD = 2'd2
  } reg_idx_t;
endpackage

FILE: sv/kte_ram.sv
`timescale 1ns / 1ps
module kte_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/kte_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor.
module kte_divider import kte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quotient,
  output logic [31:0] remainder
);
  logic [47:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[47]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 32'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;
endmodule

FILE: sv/keyframe_track_evaluator.sv
`timescale 1ns / 1ps
// Keyframe track evaluator.
// Input words arrive on the in_ stream: in_tuser carries the operation (0 adds a
// keyframe, 1 evaluates), in_tdata carries time_in in bits 31:0 and key_value_in
// in bits 63:32. Every input word yields exactly one output word on the out_
// stream, with value_out in out_tdata and the status code in out_tuser.
// Keyframes live in one synchronous RAM of time/value pairs kept sorted by time.
// An add walks down from the top of the table and moves each later entry up by
// one, reading each entry and then writing it one place higher; an add to a full
// table goes straight to output. An evaluate reads the entries in turn up to the
// segment holding the time; a hit on a segment of nonzero length runs a division
// and then easing, blending and output, while a zero-length hit, a time outside
// every segment, one keyframe and an empty table go straight to output. Looping
// first reduces the time modulo the period with a division. One word is in work
// at a time and the next is taken the cycle after the result reaches the output
// register. Configuration words are always taken but must only be sent while the
// block is idle. Reset empties the table and clears the registers. When the
// receiver stalls, the output register holds its word and a new result waits.
module keyframe_track_evaluator import kte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // time_in [31:0], key_value_in [63:32]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value_out [31:0]
  output logic [1:0]  out_tuser,  // status [1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_ARD, S_ACHK, S_AWR, S_ERD, S_ECHK, S_EDIV,
    S_EASE, S_SHAPE, S_MUL, S_BLEND, S_OUT
  } state_t;

  state_t          state_r;
  ease_t           ease_r;
  logic            loop_r;
  logic [31:0]     period_r;
  logic [CntW-1:0] count_r;
  logic [31:0]     t_r, v_r;
  logic [CntW-1:0] idx_r;
  logic [31:0]     v0_r, t1_r, v1_r;
  logic [16:0]     f_r, e_r;
  logic [33:0]     sq_r;
  logic [31:0]     prod_r;
  logic [31:0]     res_r;
  status_t         st_r;
  logic [31:0]     out_data_r;
  status_t         out_st_r;
  logic            ovalid_r;

  // RAM port
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [KeyW-1:0] wdata, rdata;

  // divider
  logic        div_start, div_done;
  logic [47:0] div_a, div_q;
  logic [31:0] div_b, div_rem;

  logic [31:0]        rd_t, rd_v;
  logic [IdxW-1:0]    idx_m1;
  logic [CntW-1:0]    last_idx;
  logic               seg_hit;
  logic               wrap_go;
  logic               in_fire;
  logic               out_free;
  logic [16:0]        g;
  logic [16:0]        sq_src;
  logic [33:0]        sq_full;
  logic [33:0]        sq_rnd16, sq_rnd15;
  logic [16:0]        e_nxt;
  logic signed [32:0] diff;
  logic signed [50:0] prod;

  kte_ram #(.Width(KeyW), .Depth(MaxKeys)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  kte_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

  assign rd_t = rdata[31:0];
  assign rd_v = rdata[63:32];

  assign idx_m1   = IdxW'(idx_r - CntW'(1));
  assign last_idx = count_r - CntW'(1);
  assign in_fire  = in_tvalid && in_tready;
  // The output register can take a new word when it is empty or being emptied.
  assign out_free = !ovalid_r || out_tready;
  // Wrapping only applies once the table holds a real segment.
  assign wrap_go  = loop_r && (period_r != '0) && (count_r > CntW'(1));
  // The previous entry is the start of the segment, the one just read its end.
  assign seg_hit  = (t_r >= t1_r) && (t_r <= rd_t);

  // Easing: a registered square, then rounding and reflection.
  assign g       = 17'd65536 - f_r;
  assign sq_full = sq_src * sq_src;
  always_comb begin
    unique case (ease_r)
      EASE_LIN:   sq_src = f_r;
      EASE_IN:    sq_src = f_r;
      EASE_OUT:   sq_src = g;
      EASE_INOUT: sq_src = f_r[16:15] == 2'b00 ? f_r : g;
    endcase
  end

  assign sq_rnd16 = sq_r + 34'd32768;
  assign sq_rnd15 = sq_r + 34'd16384;
  always_comb begin
    unique case (ease_r)
      EASE_LIN:   e_nxt = f_r;
      EASE_IN:    e_nxt = sq_rnd16[32:16];
      EASE_OUT:   e_nxt = 17'd65536 - sq_rnd16[32:16];
      EASE_INOUT: e_nxt = f_r[16:15] == 2'b00 ? sq_rnd15[31:15]
                                              : 17'd65536 - sq_rnd15[31:15];
    endcase
  end

  // Blend product with the rounding bias; the arithmetic shift floors it, and
  // only the low 32 bits of the shifted product matter for the final sum.
  assign diff = $signed({v1_r[31], v1_r}) - $signed({v0_r[31], v0_r});
  assign prod = diff * $signed({1'b0, e_r}) + 51'sd32768;

  always_comb begin
    we        = 1'b0;
    waddr     = idx_r[IdxW-1:0];
    wdata     = {v_r, t_r};
    raddr     = idx_r[IdxW-1:0];
    div_start = 1'b0;
    div_a     = {16'd0, in_tdata[31:0]};
    div_b     = period_r;
    unique case (state_r)
      S_IDLE: div_start = in_fire && (in_tuser == OP_EVAL) && (count_r != '0) && wrap_go;
      S_ARD:  raddr = idx_m1;
      S_ACHK: begin
        // A later entry moves up by one.
        we    = (rd_t > t_r);
        wdata = rdata;
      end
      S_AWR:  we = 1'b1;
      S_ECHK: begin
        div_a     = {t_r - t1_r, 16'd0};
        div_b     = rd_t - t1_r;
        div_start = (idx_r != '0) && seg_hit && (rd_t != t1_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      count_r  <= '0;
      ease_r   <= EASE_LIN;
      loop_r   <= 1'b0;
      period_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_EASE:   ease_r   <= ease_t'(cfg_data[1:0]);
          REG_LOOP:   loop_r   <= cfg_data[0];
          REG_PERIOD: period_r <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == S_OUT && out_free) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            t_r   <= in_tdata[31:0];
            v_r   <= in_tdata[63:32];
            res_r <= '0;
            if (in_tuser == OP_ADD) begin
              idx_r <= count_r;
              if (count_r == CntW'(MaxKeys)) begin
                st_r    <= ST_FULL;
                state_r <= S_OUT;
              end else begin
                st_r    <= ST_OK;
                state_r <= (count_r == '0) ? S_AWR : S_ARD;
              end
            end else begin
              idx_r <= '0;
              if (count_r == '0) begin
                st_r    <= ST_EMPTY;
                state_r <= S_OUT;
              end else begin
                st_r    <= ST_OK;
                state_r <= wrap_go ? S_WRAP : S_ERD;
              end
            end
          end
        end
        S_WRAP: begin
          if (div_done) begin
            t_r     <= div_rem;
            state_r <= S_ERD;
          end
        end
        S_ARD: state_r <= S_ACHK;
        S_ACHK: begin
          // Entries with a later time move up; an equal time stays below.
          if (rd_t > t_r) begin
            idx_r   <= idx_r - CntW'(1);
            state_r <= (idx_r == CntW'(1)) ? S_AWR : S_ARD;
          end else begin
            state_r <= S_AWR;
          end
        end
        S_AWR: begin
          count_r <= count_r + CntW'(1);
          state_r <= S_OUT;
        end
        S_ERD: state_r <= S_ECHK;
        S_ECHK: begin
          t1_r <= rd_t;
          v1_r <= rd_v;
          v0_r <= v1_r;
          if (idx_r == '0) begin
            if (count_r == CntW'(1)) begin
              res_r   <= rd_v;
              state_r <= S_OUT;
            end else begin
              idx_r   <= idx_r + CntW'(1);
              state_r <= S_ERD;
            end
          end else if (seg_hit) begin
            // A zero-length segment gives its later value.
            if (rd_t == t1_r) begin
              res_r   <= rd_v;
              state_r <= S_OUT;
            end else begin
              state_r <= S_EDIV;
            end
          end else if (idx_r == last_idx) begin
            // Outside every segment: the last keyframe's value.
            res_r   <= rd_v;
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + CntW'(1);
            state_r <= S_ERD;
          end
        end
        S_EDIV: begin
          if (div_done) begin
            f_r     <= div_q[16:0];
            state_r <= S_EASE;
          end
        end
        S_EASE: begin
          sq_r    <= sq_full;
          state_r <= S_SHAPE;
        end
        S_SHAPE: begin
          e_r     <= e_nxt;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= prod[47:16];
          state_r <= S_BLEND;
        end
        S_BLEND: begin
          res_r   <= v0_r + prod_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r <= res_r;
            out_st_r   <= st_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import kte_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // time_in [31:0], key_value_in [63:32]
  logic        in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // value_out [31:0]
  logic [1:0]  out_tuser;  // status [1:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  keyframe_track_evaluator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // One predicted output word: the blended value and the status code.
  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } track_result_t;

  // The predictor's own copy of the keyframe table and the registers.
  logic [31:0]        key_time_tbl [MaxKeys];
  logic signed [31:0] key_val_tbl [MaxKeys];
  int                 key_total;
  ease_t              ease_sel;
  logic               wrap_on;
  logic [31:0]        wrap_period;

  track_result_t pending_results[$];
  int error_count;
  int words_sent;
  int words_checked;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous ceiling on the whole run, after which the bench reports a mismatch.
  initial begin
    #50ms;
    $display("keyframe_track_evaluator: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR word %0d: %s got %h expected %h", words_checked, what, got, want);
    error_count++;
  endtask

  // Eases a Q1.16 fraction according to the selected curve.
  function automatic logic [31:0] eased_fraction(input logic [31:0] f);
    logic [63:0] ff;
    logic [63:0] g;
    ff = {32'd0, f};
    g  = 64'd65536 - ff;
    case (ease_sel)
      EASE_IN:  return 32'((ff * ff + 64'd32768) >> 16);
      EASE_OUT: return 32'(64'd65536 - ((g * g + 64'd32768) >> 16));
      EASE_INOUT: begin
        if (ff < 64'd32768) return 32'((ff * ff + 64'd16384) >> 15);
        return 32'(64'd65536 - ((g * g + 64'd16384) >> 15));
      end
      default: return f;
    endcase
  endfunction

  // Blends two values with rounding; arithmetic shift floors negative products.
  function automatic logic [31:0] blended_value(input logic signed [31:0] v0,
                                               input logic signed [31:0] v1,
                                               input logic [31:0] e);
    logic signed [63:0] d;
    logic signed [63:0] p;
    d = 64'(v1) - 64'(v0);
    p = d * $signed({32'd0, e}) + 64'sd32768;
    return 32'(64'(v0) + (p >>> 16));
  endfunction

  function automatic logic [31:0] value_at(input logic [31:0] t_raw);
    logic [31:0] t;
    logic [31:0] span;
    logic [31:0] f;
    t = t_raw;
    if (wrap_on && wrap_period != 0) t = t % wrap_period;
    for (int i = 0; i + 1 < key_total; i++) begin
      if (t >= key_time_tbl[i] && t <= key_time_tbl[i+1]) begin
        span = key_time_tbl[i+1] - key_time_tbl[i];
        if (span == 0) return key_val_tbl[i+1];
        f = 32'(({32'd0, t - key_time_tbl[i]} << 16) / {32'd0, span});
        return blended_value(key_val_tbl[i], key_val_tbl[i+1], eased_fraction(f));
      end
    end
    return key_val_tbl[key_total-1];
  endfunction

  // Applies one input word to the predicted table and returns its result.
  function automatic track_result_t track_step(input op_t op, input logic [31:0] t,
                                               input logic [31:0] v);
    track_result_t r;
    int pos;
    r.value = '0;
    r.status = ST_OK;
    if (op == OP_ADD) begin
      if (key_total >= MaxKeys) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < key_total && key_time_tbl[pos] <= t) pos++;
        for (int j = key_total; j > pos; j--) begin
          key_time_tbl[j] = key_time_tbl[j-1];
          key_val_tbl[j]  = key_val_tbl[j-1];
        end
        key_time_tbl[pos] = t;
        key_val_tbl[pos]  = v;
        key_total++;
      end
    end else if (key_total == 0) begin
      r.status = ST_EMPTY;
    end else if (key_total == 1) begin
      r.value = key_val_tbl[0];
    end else begin
      r.value = value_at(t);
    end
    return r;
  endfunction

  // Sends one word; the sender runs in bursts with random gaps between them.
  // Within a burst tvalid stays high from one word to the next.
  task automatic send_word(input op_t op, input logic [31:0] t, input logic [31:0] v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {v, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.insert(pending_results.size(), track_step(op, t, v));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_EASE:   ease_sel = ease_t'(data[1:0]);
      REG_LOOP:   wrap_on = data[0];
      default:    wrap_period = data;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Evaluates the empty table first, then adds keyframes to it; the table cannot be
  // cleared, so each test adds to what the earlier ones left.
  task automatic test_directed();
    send_word(OP_EVAL, 32'hFFFF_FFFF, 32'h1234_5678);
    send_word(OP_ADD, 32'd1000, 32'h8000_0000);
    send_word(OP_EVAL, 32'd5, '0);            // single keyframe, no wrap
    send_word(OP_ADD, 32'd3000, 32'h7FFF_FFFF);
    send_word(OP_ADD, 32'd3000, 32'h0001_0000); // equal time goes after
    send_word(OP_ADD, 32'd0, 32'hFFFF_0000);
    send_word(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001);
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_EASE, 32'(m));
      send_word(OP_EVAL, 32'd0, '0);
      send_word(OP_EVAL, 32'd1500, '0);
      send_word(OP_EVAL, 32'd2000, '0);
      send_word(OP_EVAL, 32'd3000, '0);       // end of the 1000..3000 segment
      send_word(OP_EVAL, 32'hFFFF_FFFE, '0);
    end
  endtask

  task automatic test_loop();
    write_reg(REG_LOOP, 32'hFFFF_FFFF);
    write_reg(REG_PERIOD, 32'd0);
    send_word(OP_EVAL, 32'hFFFF_FFFF, '0);
    write_reg(REG_PERIOD, 32'd2500);
    send_word(OP_EVAL, 32'd4000, '0);
    write_reg(REG_PERIOD, 32'hFFFF_FFFF);
    send_word(OP_EVAL, 32'hFFFF_FFFF, '0);
    write_reg(REG_PERIOD, 32'd1);
    send_word(OP_EVAL, 32'd77, '0);
  endtask

  function automatic logic [31:0] random_time();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 4000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 100);
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  // Random adds until the table is full, then random evaluations with an overflowing add now and then.
  task automatic test_random();
    for (int n = 0; n < 1650; n++) begin
      if (n % 200 == 0) begin
        write_reg(REG_EASE, $urandom_range(0, 3));
        write_reg(REG_LOOP, $urandom_range(0, 1));
        write_reg(REG_PERIOD, ($urandom_range(0, 1) != 0) ? $urandom_range(1, 5000)
                                                         : $urandom());
      end
      if (key_total < MaxKeys || $urandom_range(0, 15) == 0)
        send_word(OP_ADD, random_time(), $urandom());
      else
        send_word(OP_EVAL, random_time(), $urandom());
    end
  endtask

  // The receiver stalls on a slowly changing pattern, with quiet stretches.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (($time / 20000) % 4 == 3) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    track_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, '0);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata !== exp_r.value) report_mismatch("value_out", out_tdata, exp_r.value);
        if (out_tuser !== exp_r.status)
          report_mismatch("status", 32'(out_tuser), 32'(exp_r.status));
      end
      words_checked++;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_EASE;
    cfg_data = '0;
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    burst_left = 0;
    key_total = 0;
    ease_sel = EASE_LIN;
    wrap_on = 1'b0;
    wrap_period = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_loop();
    test_random();
    wait_idle();
    $display("Sent %0d words and checked %0d results across all four easing curves,",
             words_sent, words_checked);
    $display("with and without looping, including a full table and an empty one.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("keyframe_track_evaluator: match");
    end else begin
      $display("keyframe_track_evaluator: mismatch");
    end
    $finish;
  end
endmodule
